// ----- hw/rtl/sfct_pkg.sv -----
// shared types, constants and the crc-8 step for the sensor frame temperature block
// no dependencies

package sfct_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned POS_W      = 3;
   localparam int unsigned RAW_W      = 16;
   localparam int unsigned SCALED_W   = 15;
   localparam int unsigned OFFSET_W   = 12;
   localparam int unsigned TEMP_W     = 15;
   localparam int unsigned PROD_W     = 31;

   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

   // byte positions within a frame
   localparam logic [POS_W-1:0] POS_MSB      = 3'd0;
   localparam logic [POS_W-1:0] POS_LSB      = 3'd1;
   localparam logic [POS_W-1:0] POS_CRC      = 3'd2;
   localparam logic [POS_W-1:0] POS_HUM_MSB  = 3'd3;
   localparam logic [POS_W-1:0] POS_HUM_LSB  = 3'd4;
   localparam logic [POS_W-1:0] POS_HUM_CRC  = 3'd5;
   localparam logic [POS_W-1:0] POS_IDLE     = 3'd6;

   localparam logic [14:0] TEMP_SCALE = 15'd17500;
   localparam logic [15:0] DIV_ALL_ONES = 16'hFFFF;
   localparam logic signed [TEMP_W:0] TEMP_BASE = 16'sd4500;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 12'd300;

   typedef struct packed {
      logic emit;
      logic crc_error;
   } frame_event_type;

   function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ----- hw/rtl/sfct_if.sv -----
// valid/ready channel interfaces for the sensor frame temperature block
// depends on sfct_pkg

interface sfct_req_if;
   import sfct_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              frame_start;
   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface sfct_rsp_if;
   import sfct_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature_centi;
   logic                     crc_error;
   modport source (output valid, output temperature_centi, output crc_error, input ready);
   modport sink   (input valid, input temperature_centi, input crc_error, output ready);
endinterface

interface sfct_csr_if;
   import sfct_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [OFFSET_W-1:0] temp_offset_centi;
   modport source (output valid, output temp_offset_centi, input ready);
   modport sink   (input valid, input temp_offset_centi, output ready);
endinterface

// ----- hw/rtl/sfct_frame.sv -----
// frame tracker: byte position, running crc-8, raw temperature word, crc check
// depends on sfct_pkg

module sfct_frame
   import sfct_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              frame_start,
   output frame_event_type   event_out,
   output logic [RAW_W-1:0]  raw_temperature
);

   logic [POS_W-1:0]  pos_ff, pos_in, pos_eff;
   logic [BYTE_W-1:0] crc_ff, crc_in;
   logic [RAW_W-1:0]  raw_ff, raw_in;
   logic              matched_ff, matched_in;

   assign pos_eff = frame_start ? POS_MSB : pos_ff;

   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      raw_in     = raw_ff;
      matched_in = matched_ff;
      event_out  = '0;
      unique case (pos_eff)
         POS_MSB: begin
            crc_in = crc8_step(CRC_INIT, data_byte);
            raw_in = {data_byte, raw_ff[BYTE_W-1:0] & '0};
            pos_in = POS_LSB;
         end
         POS_LSB: begin
            crc_in = crc8_step(crc_ff, data_byte);
            raw_in = {raw_ff[RAW_W-1:BYTE_W], data_byte};
            pos_in = POS_CRC;
         end
         POS_CRC: begin
            matched_in = (crc_ff == data_byte);
            pos_in     = POS_HUM_MSB;
         end
         POS_HUM_MSB: pos_in = POS_HUM_LSB;
         POS_HUM_LSB: pos_in = POS_HUM_CRC;
         POS_HUM_CRC: begin
            pos_in              = POS_IDLE;
            event_out.emit      = 1'b1;
            event_out.crc_error = ~matched_ff;
         end
         default: pos_in = POS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= POS_MSB;
         crc_ff     <= CRC_INIT;
         raw_ff     <= '0;
         matched_ff <= 1'b0;
      end else if (step) begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         raw_ff     <= raw_in;
         matched_ff <= matched_in;
      end
   end

   assign raw_temperature = raw_ff;

endmodule

// ----- hw/rtl/sfct_scale.sv -----
// scales the raw word: floor(17500 * raw / 65535), registered
// depends on sfct_pkg

module sfct_scale
   import sfct_pkg::*;
(
   input  logic                clock,
   input  logic [RAW_W-1:0]    raw_temperature,
   output logic [SCALED_W-1:0] scaled
);

   logic [PROD_W-1:0]   prod;
   logic [SCALED_W-1:0] quot_lo;
   logic [RAW_W+1:0]    remainder;
   logic [SCALED_W-1:0] scaled_ff, scaled_in;

   // divide by 2^16-1: the quotient by 2^16 is low by at most one,
   // remainder against 65535 is low half plus that quotient
   assign prod      = PROD_W'(raw_temperature) * PROD_W'(TEMP_SCALE);
   assign quot_lo   = prod[PROD_W-1:RAW_W];
   assign remainder = {2'b00, prod[RAW_W-1:0]} + (RAW_W+2)'(quot_lo);
   assign scaled_in = quot_lo + SCALED_W'(remainder >= (RAW_W+2)'(DIV_ALL_ONES));

   always_ff @(posedge clock) begin
      scaled_ff <= scaled_in;
   end

   assign scaled = scaled_ff;

endmodule

// ----- hw/rtl/sensor_frame_crc_temperature_core.sv -----
// top level of the sensor frame temperature block
// depends on sfct_pkg, sfct_if, sfct_frame, sfct_scale
//
// usage:
//   req_bus takes one sensor response byte per item, frame_start marks byte 0
//   of a six-byte frame and restarts the frame wherever the tracker stood.
//   bytes 0 and 1 form the raw temperature word, byte 2 is its crc-8
//   (poly 0x31, init 0xff), bytes 3 to 5 are skipped.
//   rsp_bus gives one item per frame, on byte 5: temperature in hundredths
//   of a degree minus the offset, or crc_error with temperature zero.
//   csr_bus writes the signed offset; it is always ready, write only while idle.
// throughput: one byte item per cycle, sustained while no held result blocks byte 5.
// result path: byte 5 is captured in the input register when accepted and moves
//   on into the result register once that register is free.
// the scaling multiplier runs on the stored raw word in the background; three
//   byte items lie between byte 1 and byte 5, so it has settled by then.
// reset: frame position 0, crc 0xff, offset 300, both channels empty.
// stall: a held result keeps the input register free for non-result bytes;
//   only byte 5 waits for the result register, then req ready drops.

module sensor_frame_crc_temperature_core
   import sfct_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   sfct_req_if.sink   req_bus,
   sfct_rsp_if.source rsp_bus,
   sfct_csr_if.sink   csr_bus
);

   // input register
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_start_ff;

   // result register
   logic                     rsp_valid_ff;
   logic signed [TEMP_W-1:0] rsp_temp_ff, rsp_temp_in;
   logic                     rsp_error_ff;

   logic signed [OFFSET_W-1:0] offset_ff;

   frame_event_type     frame_ev;
   logic [RAW_W-1:0]    raw_temperature;
   logic [SCALED_W-1:0] scaled;
   logic                res_free;
   logic                in_adv;
   logic signed [TEMP_W:0] temp_wide;

   // item leaves the input register unless it needs a busy result slot
   assign res_free      = ~rsp_valid_ff | rsp_bus.ready;
   assign in_adv        = in_valid_ff & (~frame_ev.emit | res_free);
   assign req_bus.ready = ~in_valid_ff | in_adv;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.valid && req_bus.ready) begin
         in_valid_ff <= 1'b1;
      end else if (in_adv) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff  <= req_bus.data_byte;
         in_start_ff <= req_bus.frame_start;
      end
   end

   // offset register
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else if (csr_bus.valid) begin
         offset_ff <= csr_bus.temp_offset_centi;
      end
   end

   sfct_frame u_frame (
      .clock           (clock),
      .reset           (reset),
      .step            (in_adv),
      .data_byte       (in_byte_ff),
      .frame_start     (in_start_ff),
      .event_out       (frame_ev),
      .raw_temperature (raw_temperature)
   );

   sfct_scale u_scale (
      .clock           (clock),
      .raw_temperature (raw_temperature),
      .scaled          (scaled)
   );

   // scaled - 4500 - offset stays inside -6547..15048
   assign temp_wide   = $signed({1'b0, scaled}) - TEMP_BASE
                        - (TEMP_W+1)'(offset_ff);
   assign rsp_temp_in = frame_ev.crc_error ? '0 : temp_wide[TEMP_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_adv && frame_ev.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_adv && frame_ev.emit) begin
         rsp_temp_ff  <= rsp_temp_in;
         rsp_error_ff <= frame_ev.crc_error;
      end
   end

   assign rsp_bus.valid             = rsp_valid_ff;
   assign rsp_bus.temperature_centi = rsp_temp_ff;
   assign rsp_bus.crc_error         = rsp_error_ff;

endmodule

// ----- sim/testbench.sv -----
// self-checking bench for sensor_frame_crc_temperature_core: directed frames, then random
// frame traffic, checked against a byte-level frame tracker. depends on sfct_pkg, sfct_if

module testbench;
   import sfct_pkg::*;

   localparam int SCALE_NUM     = 17500;
   localparam int SCALE_DEN     = 65535;
   localparam int ZERO_OFFSET   = 4500;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 3000;
   localparam int PHASE_ITEMS   = 90;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature_centi;
      logic                     crc_error;
   } temp_result_type;

   // one directed byte; fill_crc puts the tracked word crc in place of data,
   // typed marks byte 5 rows whose result is written out by hand
   typedef struct packed {
      logic [BYTE_W-1:0]        data;
      logic                     start;
      logic                     fill_crc;
      logic                     typed;
      logic signed [TEMP_W-1:0] temp;
      logic                     err;
   } stim_row_type;

   localparam int N_ROWS = 26;
   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      // first frame after reset, no start flag; crc of 0xbeef is 0x92
      '{8'hBE, 0, 0, 0, 0, 0}, '{8'hEF, 0, 0, 0, 0, 0}, '{8'h92, 0, 0, 0, 0, 0},
      '{8'h00, 0, 0, 0, 0, 0}, '{8'hFF, 0, 0, 0, 0, 0}, '{8'h80, 0, 0, 1, 8252, 0},
      // stray byte after the frame is dropped
      '{8'hFF, 0, 0, 0, 0, 0},
      // frame abandoned after its first byte, restarted by the next start
      '{8'h00, 1, 0, 0, 0, 0},
      // full-scale raw word
      '{8'hFF, 1, 0, 0, 0, 0}, '{8'hFF, 0, 0, 0, 0, 0}, '{8'h00, 0, 1, 0, 0, 0},
      '{8'h00, 0, 0, 0, 0, 0}, '{8'h00, 0, 0, 0, 0, 0}, '{8'h00, 0, 0, 1, 12700, 0},
      // zero raw word
      '{8'h00, 1, 0, 0, 0, 0}, '{8'h00, 0, 0, 0, 0, 0}, '{8'h00, 0, 1, 0, 0, 0},
      '{8'hAA, 0, 0, 0, 0, 0}, '{8'h55, 0, 0, 0, 0, 0}, '{8'h01, 0, 0, 1, -4800, 0},
      // wrong crc byte
      '{8'hBE, 1, 0, 0, 0, 0}, '{8'hEF, 0, 0, 0, 0, 0}, '{8'h00, 0, 0, 0, 0, 0},
      '{8'h7F, 0, 0, 0, 0, 0}, '{8'hFE, 0, 0, 0, 0, 0}, '{8'h01, 0, 0, 1, 0, 1}
   };

   logic clock;
   logic reset;

   sfct_req_if req_if();
   sfct_rsp_if rsp_if();
   sfct_csr_if csr_if();

   sensor_frame_crc_temperature_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // frame tracker state
   logic [POS_W-1:0]           frame_pos;
   logic [BYTE_W-1:0]          word_crc;
   logic [RAW_W-1:0]           raw_word;
   logic                       word_ok;
   logic signed [OFFSET_W-1:0] offset_centi;

   temp_result_type pending_temps [$];
   int           mismatches  = 0;
   int           items_taken = 0;
   int           send_idle_pct = 0;
   int           rsp_stall_pct = 0;
   int           hold_left     = 0;
   int           hold_asked    = 0;
   int           hold_granted  = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] r;
      r = crc ^ b;
      repeat (BYTE_W) r = r[BYTE_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
      return r;
   endfunction

   function automatic logic signed [TEMP_W-1:0] centi_from_raw(
         input logic [RAW_W-1:0] raw, input logic signed [OFFSET_W-1:0] off);
      int t;
      t = (SCALE_NUM * int'(raw)) / SCALE_DEN - ZERO_OFFSET - int'(off);
      return TEMP_W'(t);
   endfunction

   // advances the tracker by one byte, returns 1 when the byte closes a frame
   function automatic bit track_sensor_byte(input logic [BYTE_W-1:0] b, input logic start,
                                            output temp_result_type res);
      logic [POS_W-1:0] p;
      p = start ? POS_MSB : frame_pos;
      res = '0;
      case (p)
         POS_MSB: begin
            word_crc  = crc8_next(CRC_INIT, b);
            raw_word  = {b, 8'h00};
            frame_pos = POS_LSB;
         end
         POS_LSB: begin
            word_crc      = crc8_next(word_crc, b);
            raw_word[7:0] = b;
            frame_pos     = POS_CRC;
         end
         POS_CRC: begin
            word_ok   = (word_crc == b);
            frame_pos = POS_HUM_MSB;
         end
         POS_HUM_MSB, POS_HUM_LSB: frame_pos = p + 1'b1;
         POS_HUM_CRC: begin
            frame_pos     = POS_IDLE;
            res.crc_error = !word_ok;
            if (word_ok) res.temperature_centi = centi_from_raw(raw_word, offset_centi);
            return 1'b1;
         end
         default: frame_pos = POS_IDLE;
      endcase
      return 1'b0;
   endfunction

   // offers one byte item with random gaps, then tracks it once accepted
   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic start, input bit typed,
                            input temp_result_type typed_res);
      temp_result_type got;
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid       <= 1'b1;
      req_if.data_byte   <= b;
      req_if.frame_start <= start;
      do @(posedge clock); while (!req_if.ready);
      if (start || frame_pos != POS_IDLE) items_taken++;
      if (track_sensor_byte(b, start, got)) pending_temps.push_back(typed ? typed_res : got);
   endtask

   task automatic send_plain(input logic [BYTE_W-1:0] b, input logic start);
      send_byte(b, start, 1'b0, '0);
   endtask

   // well-formed frames mostly, with some truncated frames and loose noise
   task automatic send_random_frame();
      logic [RAW_W-1:0]  raw;
      logic [BYTE_W-1:0] crc_byte;
      int                kind;
      int                cut;
      kind = $urandom_range(99);
      case ($urandom_range(9))
         0:       raw = '0;
         1:       raw = '1;
         default: raw = RAW_W'($urandom_range(16'hFFFF));
      endcase
      if (kind < 92) begin
         // truncated frames stop somewhere before byte 5
         cut = (kind < 80) ? 6 : $urandom_range(1, 5);
         send_plain(raw[15:8], ($urandom_range(19) != 0));
         if (cut > 1) send_plain(raw[7:0], 1'b0);
         if (cut > 2) begin
            crc_byte = word_crc;
            if ($urandom_range(99) < 15) crc_byte ^= BYTE_W'($urandom_range(1, 255));
            send_plain(crc_byte, 1'b0);
         end
         for (int k = 3; k < cut; k++) send_plain(BYTE_W'($urandom_range(255)), 1'b0);
      end else begin
         repeat ($urandom_range(1, 4))
            send_plain(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
      end
   endtask

   // sender stops offering until every expected result has been taken
   task automatic wait_results_drained();
      req_if.valid <= 1'b0;
      while (pending_temps.size() != 0) @(posedge clock);
   endtask

   task automatic write_offset(input logic signed [OFFSET_W-1:0] value);
      wait_results_drained();
      // bytes that close no frame may still sit in the input register
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_if.valid             <= 1'b1;
      csr_if.temp_offset_centi <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      offset_centi = value;
   endtask

   task automatic run_phase(input logic signed [OFFSET_W-1:0] off, input int idle_pct,
                            input int stall_pct, input bit hold_first, input bit pauses);
      int phase_end;
      write_offset(off);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      // long receiver hold-off while bytes keep coming: fills the block up
      if (hold_first) hold_asked++;
      phase_end = items_taken + PHASE_ITEMS;
      while (items_taken < phase_end) begin
         if (pauses && $urandom_range(7) == 0) wait_results_drained();
         send_random_frame();
      end
   endtask

   // receiver ready, with random stalls and the counted hold-off
   always @(posedge clock) begin
      if (hold_granted != hold_asked) begin
         rsp_if.ready <= 1'b0;
         hold_granted <= hold_asked;
         hold_left    <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : result_check
      temp_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_temps.size() == 0) begin
            report_mismatch("result item with none expected");
         end else begin
            want = pending_temps.pop_front();
            if (rsp_if.crc_error !== want.crc_error)
               report_mismatch($sformatf("crc_error %b, want %b",
                                         rsp_if.crc_error, want.crc_error));
            if (rsp_if.temperature_centi !== want.temperature_centi)
               report_mismatch($sformatf("temperature_centi %0d, want %0d",
                                         rsp_if.temperature_centi, want.temperature_centi));
         end
      end
   end

   // ends the run when no channel moves for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      stim_row_type    row;
      temp_result_type typed_res;
      reset                    <= 1'b1;
      req_if.valid             <= 1'b0;
      req_if.data_byte         <= '0;
      req_if.frame_start       <= 1'b0;
      csr_if.valid             <= 1'b0;
      csr_if.temp_offset_centi <= '0;
      frame_pos    = POS_MSB;
      word_crc     = CRC_INIT;
      raw_word     = '0;
      word_ok      = 1'b0;
      offset_centi = OFFSET_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed frames at the reset offset
      for (int i = 0; i < N_ROWS; i++) begin
         row = DIRECTED_ROWS[i];
         typed_res.temperature_centi = row.temp;
         typed_res.crc_error         = row.err;
         send_byte(row.fill_crc ? word_crc : row.data, row.start, row.typed, typed_res);
      end

      // random traffic, one offset setting per phase, extremes included
      run_phase(-2048, 0, 0, 1'b0, 1'b0);
      run_phase(2047, 81, 0, 1'b0, 1'b0);
      run_phase(0, 0, 81, 1'b0, 1'b0);
      run_phase(OFFSET_W'($urandom_range(4095)), 27, 27, 1'b0, 1'b0);
      run_phase(-2000, 0, 27, 1'b1, 1'b0);
      run_phase(2000, 27, 27, 1'b0, 1'b1);

      wait_results_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
